// File: hw/rtl/stack_machine_ops_core_assert.svh
// Assertion macros shared by the stack machine RTL.
`ifndef STACK_MACHINE_OPS_CORE_ASSERT_SVH
`define STACK_MACHINE_OPS_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define SMO_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle.
`define SMO_ASSERT_IMPL(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// Check that a trigger implies a condition in the next cycle.
`define SMO_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// File: hw/rtl/smo_pkg.sv
package smo_pkg;

   localparam int DATA_W = 32;
   localparam int OPC_W  = 3;

   // Opcodes as carried on the input port
   typedef enum logic [OPC_W-1:0] {
      OP_PUSH = 3'd0,
      OP_PALL = 3'd1,
      OP_PINT = 3'd2,
      OP_POP  = 3'd3,
      OP_SWAP = 3'd4,
      OP_ADD  = 3'd5,
      OP_NOP  = 3'd6
   } op_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SHORT = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Classified command handed from front to back
   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_FIX  = 3'b010,
      S_PALL = 3'b100
   } state_type;

endpackage

// File: hw/rtl/smo_front.sv
module smo_front
   import smo_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [OPC_W-1:0]         req_opcode,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     cmd_valid,
   output cmd_type                  cmd,
   input  logic                     cmd_take
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       enq, deq;
   cmd_type    enq_cmd;

   // Map the raw opcode onto a command; the unused code acts as nop
   function automatic op_type classify(input logic [OPC_W-1:0] opc);
      op_type op;
      case (opc)
         OP_PUSH: op = OP_PUSH;
         OP_PALL: op = OP_PALL;
         OP_PINT: op = OP_PINT;
         OP_POP:  op = OP_POP;
         OP_SWAP: op = OP_SWAP;
         OP_ADD:  op = OP_ADD;
         default: op = OP_NOP;
      endcase
      return op;
   endfunction

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign enq       = req_push && !req_full;
   assign deq       = cmd_take && cmd_valid;

   assign enq_cmd.op    = classify(req_opcode);
   assign enq_cmd.value = req_push_value;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (enq && !deq) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (deq && !enq) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= enq_cmd;
      end
   end

endmodule

// File: hw/rtl/smo_back.sv
module smo_back
   import smo_pkg::*;
#(
   parameter int STACK_DEPTH = 64
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  cmd_type                  cmd,
   output logic                     cmd_take,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic                     rsp_data_valid,
   output logic                     rsp_last
);

`include "stack_machine_ops_core_assert.svh"

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   // Entries below the top; the top itself lives in top_ff
   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_ff;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic [AW-1:0]     idx_ff, idx_in;
   op_type            op_ff, op_in;

   logic              rd_en, wr_en;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [CW-1:0]     cnt_m1, cnt_m2;
   logic              is_empty, is_short, is_full, out_free;

   logic              out_load;
   status_type        out_status;
   logic [DATA_W-1:0] out_data;
   logic              out_valid, out_last;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_dv_ff, rsp_last_ff;

   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_m2   = count_ff - CW'(2);
   assign is_empty = (count_ff == '0);
   assign is_short = (count_ff < CW'(2));
   assign is_full  = (count_ff == CW'(STACK_DEPTH));
   assign out_free = !rsp_valid_ff || rsp_pop;

   // Sequence each command against the stack
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      idx_in     = idx_ff;
      op_in      = op_ff;
      cmd_take   = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = cnt_m2[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = cnt_m1[AW-1:0];
      wr_data    = top_ff;
      out_load   = 1'b0;
      out_status = ST_OK;
      out_data   = '0;
      out_valid  = 1'b0;
      out_last   = 1'b1;
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               out_load = 1'b1;
               case (cmd.op)
                  OP_PUSH: begin
                     if (is_full) begin
                        out_status = ST_FULL;
                     end else begin
                        // spill the old top below the new one
                        wr_en    = !is_empty;
                        top_in   = cmd.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_PALL: begin
                     if (!is_empty) begin
                        out_data  = top_ff;
                        out_valid = 1'b1;
                        out_last  = (count_ff == CW'(1));
                        if (!out_last) begin
                           idx_in   = cnt_m2[AW-1:0];
                           rd_en    = 1'b1;
                           state_in = S_PALL;
                        end
                     end
                  end
                  OP_PINT: begin
                     if (is_empty) begin
                        out_status = ST_EMPTY;
                     end else begin
                        out_data  = top_ff;
                        out_valid = 1'b1;
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        out_status = ST_EMPTY;
                     end else if (count_ff == CW'(1)) begin
                        count_in = '0;
                     end else begin
                        rd_en    = 1'b1;
                        op_in    = OP_POP;
                        state_in = S_FIX;
                     end
                  end
                  OP_SWAP, OP_ADD: begin
                     if (is_short) begin
                        out_status = ST_SHORT;
                     end else begin
                        rd_en    = 1'b1;
                        op_in    = cmd.op;
                        state_in = S_FIX;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FIX: begin
            // second entry is now in rd_ff
            case (op_ff)
               OP_POP: begin
                  top_in   = rd_ff;
                  count_in = cnt_m1;
               end
               OP_SWAP: begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_m2[AW-1:0];
                  top_in  = rd_ff;
               end
               OP_ADD: begin
                  top_in   = rd_ff + top_ff;
                  count_in = cnt_m1;
               end
               default: begin
               end
            endcase
            state_in = S_IDLE;
         end
         S_PALL: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_data  = rd_ff;
               out_valid = 1'b1;
               out_last  = (idx_ff == '0);
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in  = idx_ff - AW'(1);
                  rd_addr = idx_ff - AW'(1);
                  rd_en   = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until the consumer takes it
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      idx_ff <= idx_in;
      op_ff  <= op_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_data_ff   <= out_data;
         rsp_dv_ff     <= out_valid;
         rsp_last_ff   <= out_last;
      end
   end

   // Stack memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_data_valid = rsp_dv_ff;
   assign rsp_last       = rsp_last_ff;

   `SMO_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(STACK_DEPTH), "stack count past depth")
   `SMO_ASSERT_IMPL(a_pall_idx, state_ff == S_PALL, (CW'(idx_ff) + CW'(1)) < count_ff, "pall index past stack")
   `SMO_ASSERT_IMPL(a_data_ok, rsp_valid_ff && rsp_dv_ff, rsp_status_ff == ST_OK, "emitted data with error status")
   `SMO_ASSERT_NEXT(a_pall_end, state_ff == S_PALL && state_in == S_IDLE, rsp_valid_ff && rsp_last_ff, "pall ended without last beat")

endmodule

// File: hw/rtl/stack_machine_ops_core.sv
// A push/pint/nop result passes the command queue, then the result register. Push, pint,
// pall-empty, nop and errors end in S_IDLE; swap, add and a deeper pop also pass S_FIX for
// the registered read of the stack memory; pall walks S_PALL, one entry a cycle while the
// result register is free. A 2-entry command queue separates input acceptance from execution.
// Reset (synchronous, active high) empties the stack and both queues; memory is not cleared.
module stack_machine_ops_core
   import smo_pkg::*;
#(
   parameter int STACK_DEPTH = 64
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [OPC_W-1:0]         req_opcode,
   input  logic signed [DATA_W-1:0] req_push_value,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic                     rsp_data_valid,
   output logic                     rsp_last
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_take;

   // Accept and classify input beats
   smo_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take)
   );

   // Execute commands against the stack
   smo_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_take       (cmd_take),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_data_valid (rsp_data_valid),
      .rsp_last       (rsp_last)
   );

endmodule

// File: tb/tb_stack_machine_ops_core.sv
`timescale 1ns / 1ps

module tb_stack_machine_ops_core;
   import smo_pkg::*;

   localparam int STACK_DEPTH  = 64;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;
   // Opcode seven has no name in the package; the block runs it as a nop
   localparam logic [OPC_W-1:0] OP_SPARE = 3'd7;

   typedef struct packed {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic                     data_valid;
      logic                     last;
   } rsp_beat_type;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_push       = 1'b0;
   logic                     req_full;
   logic [OPC_W-1:0]         req_opcode     = OP_NOP;
   logic signed [DATA_W-1:0] req_push_value = '0;
   logic                     rsp_empty;
   logic                     rsp_pop        = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic                     rsp_data_valid;
   logic                     rsp_last;

   // Predicted stack contents and the results still owed by the block
   logic signed [DATA_W-1:0] stack_image [STACK_DEPTH];
   int                       stack_level = 0;
   rsp_beat_type             pending_rsp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int err_count     = 0;
   int items_sent    = 0;
   int beats_checked = 0;
   int error_beats   = 0;
   int deepest       = 0;
   int cycle_count   = 0;

   stack_machine_ops_core #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_opcode     (req_opcode),
      .req_push_value (req_push_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_data       (rsp_data),
      .rsp_data_valid (rsp_data_valid),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bound the run in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                  cycle_count, pending_rsp.size());
         $display("tb_stack_machine_ops_core: errors");
         $finish;
      end
   end

   // Apply one command to the stack image and queue the beats it produces
   function automatic void predict_results(input logic [OPC_W-1:0] opc,
                                           input logic signed [DATA_W-1:0] val);
      rsp_beat_type beat;
      rsp_beat_type entry;
      int           idx;
      beat.status     = ST_OK;
      beat.data       = '0;
      beat.data_valid = 1'b0;
      beat.last       = 1'b1;
      case (opc)
         OP_PUSH: begin
            if (stack_level >= STACK_DEPTH) begin
               beat.status = ST_FULL;
            end else begin
               stack_image[stack_level] = val;
               stack_level++;
            end
         end
         OP_PALL: begin
            // Walk top to bottom; only the bottom entry closes the list
            for (idx = stack_level - 1; idx > 0; idx--) begin
               entry.status     = ST_OK;
               entry.data       = stack_image[idx];
               entry.data_valid = 1'b1;
               entry.last       = 1'b0;
               pending_rsp.push_back(entry);
            end
            if (stack_level > 0) begin
               beat.data       = stack_image[0];
               beat.data_valid = 1'b1;
            end
         end
         OP_PINT: begin
            if (stack_level == 0) begin
               beat.status = ST_EMPTY;
            end else begin
               beat.data       = stack_image[stack_level-1];
               beat.data_valid = 1'b1;
            end
         end
         OP_POP: begin
            if (stack_level == 0) beat.status = ST_EMPTY;
            else stack_level--;
         end
         OP_SWAP: begin
            if (stack_level < 2) begin
               beat.status = ST_SHORT;
            end else begin
               entry.data                 = stack_image[stack_level-1];
               stack_image[stack_level-1] = stack_image[stack_level-2];
               stack_image[stack_level-2] = entry.data;
            end
         end
         OP_ADD: begin
            if (stack_level < 2) begin
               beat.status = ST_SHORT;
            end else begin
               stack_image[stack_level-2] = stack_image[stack_level-2] +
                                            stack_image[stack_level-1];
               stack_level--;
            end
         end
         default: begin
         end
      endcase
      pending_rsp.push_back(beat);
      if (stack_level > deepest) deepest = stack_level;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return int'($urandom_range(0, 40)) - 20;
         1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string what, input logic [DATA_W-1:0] want_v,
                              input logic [DATA_W-1:0] got_v);
      if (want_v !== got_v) begin
         err_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
      end
   endtask

   // Drive one command beat, holding it until the block takes it
   task automatic send_beat(input logic [OPC_W-1:0] opc, input logic signed [DATA_W-1:0] val);
      // Insert idle time at the chosen rate before driving the beat
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push       <= 1'b1;
      req_opcode     <= opc;
      req_push_value <= val;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_results(opc, val);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold the input off until every owed result has come back
   task automatic wait_for_results();
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Randomly stall the result side
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each popped result beat against the oldest prediction
   always @(posedge clock) begin : check_rsp
      rsp_beat_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (rsp_status != ST_OK) error_beats++;
         if (pending_rsp.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result, expected none, actual %0d %h %b %b",
                     $time, rsp_status, rsp_data, rsp_data_valid, rsp_last);
         end else begin
            want = pending_rsp.pop_front();
            beats_checked++;
            check_field("status", DATA_W'(want.status), DATA_W'(rsp_status));
            check_field("data", want.data, rsp_data);
            check_field("data_valid", DATA_W'(want.data_valid), DATA_W'(rsp_data_valid));
            check_field("last", DATA_W'(want.last), DATA_W'(rsp_last));
         end
      end
   end

   // Every op on an empty stack, including the unnamed opcode, then swap, add and pint one deep
   task automatic test_empty_errors();
      send_beat(OP_PINT, $urandom);
      send_beat(OP_POP, $urandom);
      send_beat(OP_SWAP, $urandom);
      send_beat(OP_ADD, $urandom);
      send_beat(OP_PALL, $urandom);
      send_beat(OP_NOP, $urandom);
      send_beat(OP_SPARE, $urandom);
      send_beat(OP_PUSH, 32'sd5);
      send_beat(OP_SWAP, $urandom);
      send_beat(OP_ADD, $urandom);
      send_beat(OP_PINT, $urandom);
   endtask

   // Extreme values, wrapping add, swap and a multi-entry listing
   task automatic test_value_extremes();
      send_beat(OP_PUSH, 32'sh7fff_ffff);
      send_beat(OP_PUSH, 32'sd1);
      send_beat(OP_ADD, '0);
      send_beat(OP_PINT, '0);
      send_beat(OP_PUSH, 32'sh8000_0000);
      send_beat(OP_PUSH, -32'sd1);
      send_beat(OP_SWAP, '1);
      send_beat(OP_PALL, '1);
      send_beat(OP_ADD, '0);
      send_beat(OP_PINT, '0);
      repeat (4) send_beat(OP_POP, $urandom);
   endtask

   // Fill to the top, overflow, list it all, then unwind
   task automatic test_full_stack();
      while (stack_level < STACK_DEPTH) send_beat(OP_PUSH, pick_value());
      wait_for_results();
      repeat ($urandom_range(1, 6)) @(negedge clock);
      send_beat(OP_PUSH, $urandom);
      send_beat(OP_PUSH, $urandom);
      send_beat(OP_PALL, $urandom);
      send_beat(OP_PINT, $urandom);
      while (stack_level > 0) send_beat($urandom_range(2) == 0 ? OP_ADD : OP_POP, $urandom);
      send_beat(OP_POP, $urandom);
   endtask

   // Random ops, biased by depth so the stack wanders without pinning at either end
   task automatic test_random_mix(input int count);
      int                       pick;
      int                       push_share;
      logic [OPC_W-1:0]         opc;
      logic signed [DATA_W-1:0] val;
      repeat (count) begin
         pick       = $urandom_range(99);
         push_share = (stack_level < 4) ? 50 : (stack_level > 56) ? 15 : 32;
         if (pick < push_share) opc = OP_PUSH;
         else if (pick < push_share + 14) opc = OP_POP;
         else if (pick < push_share + 26) opc = OP_SWAP;
         else if (pick < push_share + 38) opc = OP_ADD;
         else if (pick < push_share + 48) opc = OP_PINT;
         else if (pick < push_share + 52) opc = OP_PALL;
         else if (pick < 97) opc = OP_NOP;
         else opc = OP_SPARE;
         val = (opc == OP_PUSH) ? pick_value() : $urandom;
         send_beat(opc, val);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender lightly idle, receiver heavily stalled
      send_idle_pct = 29;
      recv_idle_pct = 61;
      test_empty_errors();
      test_value_extremes();
      test_random_mix(100);
      test_full_stack();

      // Sender heavily idle, receiver lightly stalled
      send_idle_pct = 61;
      recv_idle_pct = 29;
      test_random_mix(100);

      // Full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_mix(100);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d commands sent, %0d result beats checked (%0d with error status)",
               items_sent, beats_checked, error_beats);
      $display("stack reached depth %0d of %0d, including overflow and underflow cases",
               deepest, STACK_DEPTH);
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("tb_stack_machine_ops_core: clean");
      end else begin
         $display("tb_stack_machine_ops_core: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/smo_pkg.sv
hw/rtl/smo_front.sv
hw/rtl/smo_back.sv
hw/rtl/stack_machine_ops_core.sv
tb/tb_stack_machine_ops_core.sv
